// ===== design/uart16_pkg.sv =====
// shared types, constants and tables of the 16550-style uart register model
package uart16_pkg;

   localparam int FifoDepthDef    = 16;
   localparam int TimeoutTicksDef = 4;

   // request kinds
   localparam logic [2:0] FUNC_READ   = 3'd0;
   localparam logic [2:0] FUNC_WRITE  = 3'd1;
   localparam logic [2:0] FUNC_RXBYTE = 3'd2;
   localparam logic [2:0] FUNC_TXPOP  = 3'd3;
   localparam logic [2:0] FUNC_TXDONE = 3'd4;
   localparam logic [2:0] FUNC_TICK   = 3'd5;
   localparam logic [2:0] FUNC_MODEM  = 3'd6;

   // register offsets
   localparam logic [2:0] REG_DATA = 3'd0;
   localparam logic [2:0] REG_IER  = 3'd1;
   localparam logic [2:0] REG_IIR  = 3'd2;
   localparam logic [2:0] REG_LCR  = 3'd3;
   localparam logic [2:0] REG_MCR  = 3'd4;
   localparam logic [2:0] REG_LSR  = 3'd5;
   localparam logic [2:0] REG_MSR  = 3'd6;
   localparam logic [2:0] REG_SCR  = 3'd7;

   // pending causes
   localparam logic [2:0] CAUSE_NONE  = 3'd0;
   localparam logic [2:0] CAUSE_LINE  = 3'd1;
   localparam logic [2:0] CAUSE_TMO   = 3'd2;
   localparam logic [2:0] CAUSE_RXD   = 3'd3;
   localparam logic [2:0] CAUSE_THRE  = 3'd4;
   localparam logic [2:0] CAUSE_MODEM = 3'd5;

   localparam logic [7:0] LSR_DR    = 8'h01;
   localparam logic [7:0] LSR_OE    = 8'h02;
   localparam logic [7:0] LSR_ERR   = 8'h1e;
   localparam logic [7:0] LSR_THRE  = 8'h20;
   localparam logic [7:0] LSR_TEMT  = 8'h40;
   localparam logic [7:0] LSR_RESET = 8'h60;
   localparam logic [7:0] MSR_DELTA = 8'h0f;
   localparam logic [7:0] MSR_RESET = 8'h30;

   localparam logic [5:0] EV_IRQ   = 6'h01;
   localparam logic [5:0] EV_HOST  = 6'h02;
   localparam logic [5:0] EV_RXRST = 6'h04;
   localparam logic [5:0] EV_TXRST = 6'h08;
   localparam logic [5:0] EV_TMO   = 6'h10;
   localparam logic [5:0] EV_MODEM = 6'h20;

   typedef enum logic {ST_IDLE, ST_FETCH} state_type;

   function automatic logic [3:0] trig_level(input logic [1:0] sel);
      logic [3:0] t;
      case (sel)
         2'd0:    t = 4'd1;
         2'd1:    t = 4'd4;
         2'd2:    t = 4'd8;
         default: t = 4'd14;
      endcase
      return t;
   endfunction

   function automatic logic [7:0] iir_code(input logic [2:0] cause);
      logic [7:0] c;
      case (cause)
         CAUSE_LINE:  c = 8'h06;
         CAUSE_TMO:   c = 8'h0c;
         CAUSE_RXD:   c = 8'h04;
         CAUSE_THRE:  c = 8'h02;
         CAUSE_MODEM: c = 8'h00;
         default:     c = 8'h01;
      endcase
      return c;
   endfunction

   // msr line bits driven from mcr in loopback
   function automatic logic [7:0] loop_lines(input logic [7:0] mcr);
      return {mcr[3], mcr[2], mcr[0], mcr[1], 4'h0};
   endfunction

   function automatic logic [7:0] line_deltas(input logic [7:0] old_l, input logic [7:0] new_l);
      logic [7:0] x;
      x = old_l ^ new_l;
      return {4'h0, x[7], old_l[6] & ~new_l[6], x[5], x[4]};
   endfunction

endpackage

// ===== design/uart16_if.sv =====
// request and response channel interfaces
interface uart16_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] func;
   logic [2:0] reg_offset;
   logic [7:0] write_data;
   logic [7:0] rx_byte;
   logic [3:0] modem_lines;
   logic       clear_deltas;
   modport source (output valid, func, reg_offset, write_data, rx_byte, modem_lines,
                   clear_deltas, input ready);
   modport sink (input valid, func, reg_offset, write_data, rx_byte, modem_lines,
                 clear_deltas, output ready);
endinterface

interface uart16_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic [7:0] tx_byte;
   logic       tx_valid;
   logic       rx_accepted;
   logic [2:0] pending_cause;
   logic       irq_out;
   logic [5:0] event_flags;
   logic       dtr_out;
   logic       rts_out;
   modport source (output valid, read_data, tx_byte, tx_valid, rx_accepted, pending_cause,
                   irq_out, event_flags, dtr_out, rts_out, input ready);
   modport sink (input valid, read_data, tx_byte, tx_valid, rx_accepted, pending_cause,
                 irq_out, event_flags, dtr_out, rts_out, output ready);
endinterface

// ===== design/uart16_ram.sv =====
// generic single-write, single-read ram with registered read
module uart16_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                      wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                      rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

// ===== design/uart_16550_register_model.sv =====
// top level of the 16550-style uart register model with rx and tx fifo memories
//
//   channel  | dir | handshake    | carries
//   req_chan | in  | valid/ready  | func, reg_offset, write_data, rx_byte, modem_lines, ...
//   rsp_chan | out | valid/ready  | read_data, tx_byte, flags, pending cause, irq, lines
//
// a data register read or tx pop that finds a byte passes through the fetch state, which
// takes the registered read of the fifo memory into the response.
// one request is in work at a time; the response register frees as it is taken,
// so a new request is accepted in the cycle the previous response leaves.
// synchronous reset returns all control registers to their reset values; fifo contents are not cleared.
module uart_16550_register_model #(
   parameter int FIFO_DEPTH    = uart16_pkg::FifoDepthDef,
   parameter int TIMEOUT_TICKS = uart16_pkg::TimeoutTicksDef
) (
   input logic        clock,
   input logic        reset,
   uart16_req_if.sink   req_chan,
   uart16_rsp_if.source rsp_chan
);
   localparam int AW = FIFO_DEPTH > 1 ? $clog2(FIFO_DEPTH) : 1;
   localparam int CW = $clog2(FIFO_DEPTH + 1);
   localparam int TW = $clog2(TIMEOUT_TICKS + 1);

   uart16_pkg::state_type st_ff, st_in;

   logic [AW-1:0] rx_head_ff, rx_head_in, rx_tail_ff, rx_tail_in;
   logic [CW-1:0] rx_cnt_ff, rx_cnt_in;
   logic [AW-1:0] tx_head_ff, tx_head_in, tx_tail_ff, tx_tail_in;
   logic [CW-1:0] tx_cnt_ff, tx_cnt_in;
   logic [3:0] ier_ff, ier_in;
   logic [7:0] lcr_ff, lcr_in, mcr_ff, mcr_in, lsr_ff, lsr_in, msr_ff, msr_in;
   logic [7:0] scr_ff, scr_in, dll_ff, dll_in, dlm_ff, dlm_in;
   logic       fon_ff, fon_in;
   logic [3:0] trig_ff, trig_in;
   logic [2:0] pend_ff, pend_in;
   logic       irq_ff, irq_in;
   logic       tarm_ff, tarm_in, tfire_ff, tfire_in;
   logic [TW-1:0] tcnt_ff, tcnt_in;

   logic       ovld_ff, ovld_in;
   logic [7:0] ord_ff, ord_in, otxb_ff, otxb_in;
   logic       otxv_ff, otxv_in, oacc_ff, oacc_in;
   logic [5:0] oev_ff, oev_in;
   logic       odtr_ff, odtr_in, orts_ff, orts_in;
   logic       fsel_ff, fsel_in;   // 1: fetched byte goes to tx_byte, 0: read_data

   logic       accept, need_mem;
   logic       rx_we, tx_we;
   logic [7:0] rx_rdata, tx_rdata;
   logic [7:0] rx_wdata;

   assign req_chan.ready = (st_ff == uart16_pkg::ST_IDLE) && (!ovld_ff || rsp_chan.ready);
   assign accept = req_chan.valid && req_chan.ready;

   uart16_ram #(.WIDTH(8), .DEPTH(FIFO_DEPTH)) u_rx_ram (
      .clock(clock), .we(rx_we), .waddr(rx_tail_ff), .wdata(rx_wdata),
      .raddr(rx_head_ff), .rdata(rx_rdata));

   uart16_ram #(.WIDTH(8), .DEPTH(FIFO_DEPTH)) u_tx_ram (
      .clock(clock), .we(tx_we), .waddr(tx_tail_ff), .wdata(req_chan.write_data),
      .raddr(tx_head_ff), .rdata(tx_rdata));

   // item processing
   always_comb begin
      logic dlab, rx_full, tx_full, at_trig;
      logic [7:0] nl, dl;
      logic [5:0] ev;
      logic [2:0] p;
      rx_head_in = rx_head_ff; rx_tail_in = rx_tail_ff; rx_cnt_in = rx_cnt_ff;
      tx_head_in = tx_head_ff; tx_tail_in = tx_tail_ff; tx_cnt_in = tx_cnt_ff;
      ier_in = ier_ff; lcr_in = lcr_ff; mcr_in = mcr_ff; lsr_in = lsr_ff;
      msr_in = msr_ff; scr_in = scr_ff; dll_in = dll_ff; dlm_in = dlm_ff;
      fon_in = fon_ff; trig_in = trig_ff; tarm_in = tarm_ff; tfire_in = tfire_ff;
      tcnt_in = tcnt_ff;
      ord_in = 8'h00; otxv_in = 1'b0; oacc_in = 1'b0; ev = 6'h00;
      rx_we = 1'b0; tx_we = 1'b0; rx_wdata = req_chan.rx_byte;
      need_mem = 1'b0; fsel_in = fsel_ff;
      dlab = lcr_ff[7];
      rx_full = rx_cnt_ff == CW'(FIFO_DEPTH);
      tx_full = tx_cnt_ff == CW'(FIFO_DEPTH);
      nl = 8'h00; dl = 8'h00;

      if (accept) begin
         case (req_chan.func)
            uart16_pkg::FUNC_READ: begin
               if (dlab && req_chan.reg_offset == uart16_pkg::REG_DATA) begin
                  ord_in = dll_ff;
               end else if (dlab && req_chan.reg_offset == uart16_pkg::REG_IER) begin
                  ord_in = dlm_ff;
               end else begin
                  unique case (req_chan.reg_offset)
                     uart16_pkg::REG_DATA: begin
                        if (rx_cnt_ff != '0) begin
                           need_mem = 1'b1;
                           fsel_in = 1'b0;
                           rx_head_in = (rx_head_ff == AW'(FIFO_DEPTH - 1)) ? '0
                                        : rx_head_ff + 1'b1;
                           rx_cnt_in = rx_cnt_ff - 1'b1;
                           tfire_in = 1'b0;
                           if (rx_cnt_in == '0) begin
                              lsr_in = lsr_ff & ~uart16_pkg::LSR_DR;
                              tarm_in = 1'b0;
                           end else if (9'(rx_cnt_in) < 9'(trig_ff)) begin
                              tarm_in = 1'b1;
                              tcnt_in = TW'(TIMEOUT_TICKS);
                           end
                        end
                     end
                     uart16_pkg::REG_IER: ord_in = {4'h0, ier_ff};
                     uart16_pkg::REG_IIR:
                        ord_in = uart16_pkg::iir_code(pend_ff) | {fon_ff, fon_ff, 6'h00};
                     uart16_pkg::REG_LCR: ord_in = lcr_ff;
                     uart16_pkg::REG_MCR: ord_in = mcr_ff;
                     uart16_pkg::REG_LSR: begin
                        ord_in = lsr_ff;
                        lsr_in = lsr_ff & ~uart16_pkg::LSR_ERR;
                     end
                     uart16_pkg::REG_MSR: begin
                        ord_in = mcr_ff[4] ? ((msr_ff & uart16_pkg::MSR_DELTA) |
                                              uart16_pkg::loop_lines(mcr_ff)) : msr_ff;
                        msr_in = msr_ff & ~uart16_pkg::MSR_DELTA;
                     end
                     default: ord_in = scr_ff;
                  endcase
               end
            end
            uart16_pkg::FUNC_WRITE: begin
               if (dlab && req_chan.reg_offset == uart16_pkg::REG_DATA) begin
                  dll_in = req_chan.write_data;
               end else if (dlab && req_chan.reg_offset == uart16_pkg::REG_IER) begin
                  dlm_in = req_chan.write_data;
               end else begin
                  unique case (req_chan.reg_offset)
                     uart16_pkg::REG_DATA: begin
                        if (mcr_ff[4]) begin
                           rx_wdata = req_chan.write_data;
                           if (!rx_full) begin
                              rx_we = 1'b1;
                              rx_tail_in = (rx_tail_ff == AW'(FIFO_DEPTH - 1)) ? '0
                                           : rx_tail_ff + 1'b1;
                              rx_cnt_in = rx_cnt_ff + 1'b1;
                              lsr_in = lsr_ff | uart16_pkg::LSR_DR;
                              if (9'(rx_cnt_in) < 9'(trig_ff)) begin
                                 tarm_in = 1'b1;
                                 tcnt_in = TW'(TIMEOUT_TICKS);
                              end else begin
                                 tarm_in = 1'b0;
                                 tfire_in = 1'b0;
                              end
                           end else begin
                              lsr_in = lsr_ff | uart16_pkg::LSR_OE;
                           end
                        end else if (!tx_full) begin
                           tx_we = 1'b1;
                           tx_tail_in = (tx_tail_ff == AW'(FIFO_DEPTH - 1)) ? '0
                                        : tx_tail_ff + 1'b1;
                           tx_cnt_in = tx_cnt_ff + 1'b1;
                           lsr_in = lsr_ff & ~(uart16_pkg::LSR_THRE | uart16_pkg::LSR_TEMT);
                        end
                     end
                     uart16_pkg::REG_IER: ier_in = req_chan.write_data[3:0];
                     uart16_pkg::REG_IIR: begin
                        // disabling the fifos, or the reset bits, flush the queues
                        if (!req_chan.write_data[0] && fon_ff) begin
                           rx_head_in = '0; rx_tail_in = '0; rx_cnt_in = '0;
                           tx_head_in = '0; tx_tail_in = '0; tx_cnt_in = '0;
                           lsr_in = (lsr_in & ~uart16_pkg::LSR_DR) |
                                    uart16_pkg::LSR_THRE | uart16_pkg::LSR_TEMT;
                           tarm_in = 1'b0; tfire_in = 1'b0;
                           ev = ev | uart16_pkg::EV_RXRST | uart16_pkg::EV_TXRST;
                        end
                        fon_in = req_chan.write_data[0];
                        if (req_chan.write_data[1]) begin
                           rx_head_in = '0; rx_tail_in = '0; rx_cnt_in = '0;
                           lsr_in = lsr_in & ~(uart16_pkg::LSR_DR | uart16_pkg::LSR_OE);
                           tarm_in = 1'b0; tfire_in = 1'b0;
                           ev = ev | uart16_pkg::EV_RXRST;
                        end
                        if (req_chan.write_data[2]) begin
                           tx_head_in = '0; tx_tail_in = '0; tx_cnt_in = '0;
                           lsr_in = lsr_in | uart16_pkg::LSR_THRE | uart16_pkg::LSR_TEMT;
                           ev = ev | uart16_pkg::EV_TXRST;
                        end
                        trig_in = fon_in ? uart16_pkg::trig_level(req_chan.write_data[7:6])
                                         : 4'd1;
                     end
                     uart16_pkg::REG_LCR: lcr_in = req_chan.write_data;
                     uart16_pkg::REG_MCR: begin
                        mcr_in = req_chan.write_data;
                        if (req_chan.write_data[4]) begin
                           nl = uart16_pkg::loop_lines(req_chan.write_data);
                           msr_in = nl | (msr_ff & uart16_pkg::MSR_DELTA) |
                                    uart16_pkg::line_deltas(msr_ff & 8'hf0, nl);
                        end else if ((mcr_ff[1:0] ^ req_chan.write_data[1:0]) != 2'b00) begin
                           ev = ev | uart16_pkg::EV_HOST;
                        end
                     end
                     uart16_pkg::REG_SCR: scr_in = req_chan.write_data;
                     default: ;
                  endcase
               end
            end
            uart16_pkg::FUNC_RXBYTE: begin
               if (!rx_full) begin
                  rx_we = 1'b1;
                  oacc_in = 1'b1;
                  rx_tail_in = (rx_tail_ff == AW'(FIFO_DEPTH - 1)) ? '0 : rx_tail_ff + 1'b1;
                  rx_cnt_in = rx_cnt_ff + 1'b1;
               end else begin
                  lsr_in = lsr_ff | uart16_pkg::LSR_OE;
               end
               if (rx_cnt_in != '0) begin
                  lsr_in = lsr_in | uart16_pkg::LSR_DR;
                  if (9'(rx_cnt_in) < 9'(trig_ff)) begin
                     tarm_in = 1'b1;
                     tcnt_in = TW'(TIMEOUT_TICKS);
                  end else begin
                     tarm_in = 1'b0;
                     tfire_in = 1'b0;
                  end
               end
            end
            uart16_pkg::FUNC_TXPOP: begin
               if (tx_cnt_ff != '0) begin
                  need_mem = 1'b1;
                  fsel_in = 1'b1;
                  otxv_in = 1'b1;
                  tx_head_in = (tx_head_ff == AW'(FIFO_DEPTH - 1)) ? '0 : tx_head_ff + 1'b1;
                  tx_cnt_in = tx_cnt_ff - 1'b1;
               end
            end
            uart16_pkg::FUNC_TXDONE: begin
               if (tx_cnt_ff == '0) begin
                  lsr_in = lsr_ff | uart16_pkg::LSR_THRE | uart16_pkg::LSR_TEMT;
               end
            end
            uart16_pkg::FUNC_TICK: begin
               if (tarm_ff && !tfire_ff) begin
                  if (tcnt_ff != '0) begin
                     tcnt_in = tcnt_ff - 1'b1;
                  end
                  if (tcnt_in == '0) begin
                     tarm_in = 1'b0;
                     if (rx_cnt_ff != '0) begin
                        tfire_in = 1'b1;
                        ev = ev | uart16_pkg::EV_TMO;
                     end
                  end
               end
            end
            uart16_pkg::FUNC_MODEM: begin
               nl = {req_chan.modem_lines, 4'h0};
               dl = req_chan.clear_deltas ? 8'h00 : (msr_ff & uart16_pkg::MSR_DELTA);
               msr_in = nl | dl | uart16_pkg::line_deltas(msr_ff & 8'hf0, nl);
               if (msr_in != msr_ff) begin
                  ev = ev | uart16_pkg::EV_MODEM;
               end
            end
            default: ;
         endcase
      end

      // interrupt priority on the updated state
      at_trig = lsr_in[0] && (9'(rx_cnt_in) >= 9'(trig_in));
      if (ier_in[2] && (lsr_in & uart16_pkg::LSR_ERR) != 8'h00) begin
         p = uart16_pkg::CAUSE_LINE;
      end else if (ier_in[0] && tfire_in) begin
         p = uart16_pkg::CAUSE_TMO;
      end else if (ier_in[0] && at_trig) begin
         p = uart16_pkg::CAUSE_RXD;
      end else if (ier_in[1] && lsr_in[5]) begin
         p = uart16_pkg::CAUSE_THRE;
      end else if (ier_in[3] && (msr_in & uart16_pkg::MSR_DELTA) != 8'h00) begin
         p = uart16_pkg::CAUSE_MODEM;
      end else begin
         p = uart16_pkg::CAUSE_NONE;
      end
      pend_in = p;
      irq_in = (p != uart16_pkg::CAUSE_NONE) && mcr_in[3];
      if (pend_in != pend_ff || irq_in != irq_ff) begin
         ev = ev | uart16_pkg::EV_IRQ;
      end
      oev_in = ev;
      odtr_in = ev[1] & mcr_in[0];
      orts_in = ev[1] & mcr_in[1];
   end

   // next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         uart16_pkg::ST_IDLE:  if (accept && need_mem) st_in = uart16_pkg::ST_FETCH;
         uart16_pkg::ST_FETCH: st_in = uart16_pkg::ST_IDLE;
         default:              st_in = uart16_pkg::ST_IDLE;
      endcase
   end

   // response register control
   always_comb begin
      ovld_in = ovld_ff && !rsp_chan.ready;
      otxb_in = otxb_ff;
      unique case (st_ff)
         uart16_pkg::ST_IDLE: begin
            if (accept) begin
               ovld_in = !need_mem;
               otxb_in = 8'h00;
            end
         end
         uart16_pkg::ST_FETCH: begin
            ovld_in = 1'b1;
            otxb_in = fsel_ff ? tx_rdata : 8'h00;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= uart16_pkg::ST_IDLE;
         ovld_ff <= 1'b0;
         rx_head_ff <= '0; rx_tail_ff <= '0; rx_cnt_ff <= '0;
         tx_head_ff <= '0; tx_tail_ff <= '0; tx_cnt_ff <= '0;
         ier_ff <= 4'h0; lcr_ff <= 8'h00; mcr_ff <= 8'h00;
         lsr_ff <= uart16_pkg::LSR_RESET; msr_ff <= uart16_pkg::MSR_RESET;
         scr_ff <= 8'h00; dll_ff <= 8'h00; dlm_ff <= 8'h00;
         fon_ff <= 1'b0; trig_ff <= 4'd1;
         pend_ff <= uart16_pkg::CAUSE_NONE; irq_ff <= 1'b0;
         tarm_ff <= 1'b0; tfire_ff <= 1'b0; tcnt_ff <= '0;
      end else begin
         st_ff <= st_in;
         ovld_ff <= ovld_in;
         rx_head_ff <= rx_head_in; rx_tail_ff <= rx_tail_in; rx_cnt_ff <= rx_cnt_in;
         tx_head_ff <= tx_head_in; tx_tail_ff <= tx_tail_in; tx_cnt_ff <= tx_cnt_in;
         ier_ff <= ier_in; lcr_ff <= lcr_in; mcr_ff <= mcr_in;
         lsr_ff <= lsr_in; msr_ff <= msr_in;
         scr_ff <= scr_in; dll_ff <= dll_in; dlm_ff <= dlm_in;
         fon_ff <= fon_in; trig_ff <= trig_in;
         pend_ff <= pend_in; irq_ff <= irq_in;
         tarm_ff <= tarm_in; tfire_ff <= tfire_in; tcnt_ff <= tcnt_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      otxb_ff <= otxb_in;
      if (accept) begin
         ord_ff <= ord_in;
         otxv_ff <= otxv_in;
         oacc_ff <= oacc_in;
         oev_ff <= oev_in;
         odtr_ff <= odtr_in;
         orts_ff <= orts_in;
         fsel_ff <= fsel_in;
      end else if (st_ff == uart16_pkg::ST_FETCH && !fsel_ff) begin
         ord_ff <= rx_rdata;
      end
   end

   assign rsp_chan.valid         = ovld_ff;
   assign rsp_chan.read_data     = ord_ff;
   assign rsp_chan.tx_byte       = otxb_ff;
   assign rsp_chan.tx_valid      = otxv_ff;
   assign rsp_chan.rx_accepted   = oacc_ff;
   assign rsp_chan.pending_cause = pend_ff;
   assign rsp_chan.irq_out       = irq_ff;
   assign rsp_chan.event_flags   = oev_ff;
   assign rsp_chan.dtr_out       = odtr_ff;
   assign rsp_chan.rts_out       = orts_ff;

   a_rx_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      rx_cnt_ff <= CW'(FIFO_DEPTH) && tx_cnt_ff <= CW'(FIFO_DEPTH))
      else $error("fifo count beyond depth");
   a_dr_matches_cnt: assert property (@(posedge clock) disable iff (reset)
      lsr_ff[0] == (rx_cnt_ff != '0))
      else $error("data ready out of step with rx fill");
   a_irq_needs_cause: assert property (@(posedge clock) disable iff (reset)
      irq_ff |-> pend_ff != uart16_pkg::CAUSE_NONE)
      else $error("irq without pending cause");
   a_fetch_responds: assert property (@(posedge clock) disable iff (reset)
      st_ff == uart16_pkg::ST_FETCH |=> ovld_ff)
      else $error("fetch did not produce a response");
endmodule
